### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the decoder checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

### rtl/lpid_pkg.sv
// ----------------------------------------------------------------------------
// lpid_pkg
// Shared types and constants of the LZSS pixel index decoder.
// ----------------------------------------------------------------------------
package lpid_pkg;

    localparam int unsigned CNT_W   = 17;  // pixel counter and total width
    localparam int unsigned GROUP_W = 64;  // up to eight 8-bit indices
    localparam int unsigned PXCNT_W = 4;

    localparam logic [CNT_W-1:0] TOTAL_RESET = 17'd65536;

    localparam logic [8:0] MATCH_BIAS     = 9'd3;
    localparam logic [8:0] DIST_BIAS      = 9'd1;
    localparam logic [3:0] FLAGS_PER_CTRL = 4'd8;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_DIST_ERR = 1'b1;

    typedef logic [7:0] pixel_t;

endpackage

### rtl/lpid_window_ram.sv
// ----------------------------------------------------------------------------
// lpid_window_ram
// History window: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lpid_window_ram #(
    parameter int unsigned DEPTH = 65536,
    parameter int unsigned AW    = 16
) (
    input  logic               aclk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  lpid_pkg::pixel_t   wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr,
    output lpid_pkg::pixel_t   rdata
);

    lpid_pkg::pixel_t mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/lzss_pixel_index_decoder.sv
// ----------------------------------------------------------------------------
// lzss_pixel_index_decoder
// LZSS stream decoder producing 8-bit pixel indices in groups.
// ----------------------------------------------------------------------------
// Channel   Dir  Signals                                      Beat
// s_        in   s_valid s_ready s_stream_byte                one stream byte
// m_        out  m_valid m_ready m_status m_pixel_group       one pixel group
//                m_pixel_count m_last_of_token                or an error
// cfg_      in   cfg_valid cfg_ready cfg_data                 total_pixels
//
// Sequencing: control and length bytes are taken in ST_IDLE alone; a literal
// passes ST_IDLE then ST_EMIT, plus any wait on m_ready. A match passes ST_SETUP,
// then ST_RD and ST_WR for each pixel (window read, then write-back), plus ST_EMIT
// for each emitted group. The single window RAM port pair sets the per-pixel steps.
// Reset (aresetn low, synchronous) clears parser state, counters and the
// output valid flag; the window RAM is not cleared.
// s_ready is high only while the sequencer is idle; the output register
// holds a finished group while the next byte is taken.
// ----------------------------------------------------------------------------
module lzss_pixel_index_decoder #(
    parameter int unsigned WINDOW_DEPTH = 65536,
    parameter int unsigned GROUP_PIXELS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_stream_byte,

    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_status,
    output logic [63:0] m_pixel_group,
    output logic [3:0]  m_pixel_count,
    output logic        m_last_of_token,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data
);

    localparam int unsigned AW = $clog2(WINDOW_DEPTH);
    localparam logic [AW-1:0] PTR_LAST  = AW'(WINDOW_DEPTH - 1);
    localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(WINDOW_DEPTH);
    localparam logic [3:0]    GRP_N     = 4'(GROUP_PIXELS);

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;  // take a stream byte
    localparam logic [2:0] ST_SETUP = 3'd1;  // check distance, clip length
    localparam logic [2:0] ST_RD    = 3'd2;  // issue window read
    localparam logic [2:0] ST_WR    = 3'd3;  // write pixel back, pack it
    localparam logic [2:0] ST_EMIT  = 3'd4;  // hand group to output register

    logic [2:0]  state_reg, state_next;

    // parser state
    logic [16:0] done_reg, done_next;
    logic [16:0] total_reg, total_next;
    logic [7:0]  flag_reg, flag_next;
    logic [3:0]  pos_reg, pos_next;
    logic        phase_reg, phase_next;
    logic [7:0]  plen_reg, plen_next;
    logic [7:0]  dist_reg, dist_next;
    logic        halted_reg, halted_next;

    // match engine
    logic [AW-1:0] wptr_reg, wptr_next;
    logic [AW-1:0] rptr_reg, rptr_next;
    logic [8:0]    rem_reg, rem_next;

    // group being built
    logic [63:0] grp_reg, grp_next;
    logic [3:0]  fill_reg, fill_next;
    logic        elast_reg, elast_next;
    logic        estat_reg, estat_next;

    // output register
    logic        mv_reg, mv_next;
    logic        ms_reg, ms_next;
    logic [63:0] mg_reg, mg_next;
    logic [3:0]  mc_reg, mc_next;
    logic        ml_reg, ml_next;

    // window RAM port
    logic              win_we, win_re;
    logic [AW-1:0]     win_waddr;
    lpid_pkg::pixel_t  win_wdata, win_rdata;

    logic        s_fire;
    logic [8:0]  dist_w, len_w;
    logic [16:0] room_w;
    logic [AW:0] back_w;

    lpid_window_ram #(
        .DEPTH (WINDOW_DEPTH),
        .AW    (AW)
    ) u_win (
        .aclk  (aclk),
        .we    (win_we),
        .waddr (win_waddr),
        .wdata (win_wdata),
        .re    (win_re),
        .raddr (rptr_reg),
        .rdata (win_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    assign m_valid         = mv_reg;
    assign m_status        = ms_reg;
    assign m_pixel_group   = mg_reg;
    assign m_pixel_count   = mc_reg;
    assign m_last_of_token = ml_reg;

    // match setup arithmetic
    assign dist_w = {1'b0, dist_reg} + lpid_pkg::DIST_BIAS;
    assign len_w  = {1'b0, plen_reg} + lpid_pkg::MATCH_BIAS;
    assign room_w = total_reg - done_reg;
    assign back_w = {1'b0, wptr_reg} - (AW + 1)'(dist_w);

    always_comb begin
        state_next  = state_reg;
        done_next   = done_reg;
        total_next  = total_reg;
        flag_next   = flag_reg;
        pos_next    = pos_reg;
        phase_next  = phase_reg;
        plen_next   = plen_reg;
        dist_next   = dist_reg;
        halted_next = halted_reg;
        wptr_next   = wptr_reg;
        rptr_next   = rptr_reg;
        rem_next    = rem_reg;
        grp_next    = grp_reg;
        fill_next   = fill_reg;
        elast_next  = elast_reg;
        estat_next  = estat_reg;
        mv_next     = mv_reg;
        ms_next     = ms_reg;
        mg_next     = mg_reg;
        mc_next     = mc_reg;
        ml_next     = ml_reg;
        win_we      = 1'b0;
        win_re      = 1'b0;
        win_waddr   = wptr_reg;
        win_wdata   = s_stream_byte;

        if (cfg_valid) begin
            total_next = cfg_data;
        end

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                // bytes after a halt or a finished image are dropped
                if (s_fire && !halted_reg && (done_reg < total_reg)) begin
                    if (phase_reg) begin
                        phase_next = 1'b0;
                        pos_next   = pos_reg + 4'd1;
                        dist_next  = s_stream_byte;
                        state_next = ST_SETUP;
                    end else if (pos_reg >= lpid_pkg::FLAGS_PER_CTRL) begin
                        flag_next = s_stream_byte;
                        pos_next  = 4'd0;
                    end else if (!flag_reg[pos_reg[2:0]]) begin
                        // literal pixel
                        win_we     = 1'b1;
                        wptr_next  = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
                        done_next  = done_reg + 17'd1;
                        pos_next   = pos_reg + 4'd1;
                        grp_next   = {56'd0, s_stream_byte};
                        fill_next  = 4'd1;
                        elast_next = 1'b1;
                        estat_next = lpid_pkg::STATUS_OK;
                        state_next = ST_EMIT;
                    end else begin
                        plen_next  = s_stream_byte;
                        phase_next = 1'b1;
                    end
                end
            end
            ST_SETUP: begin
                if ({8'd0, dist_w} > done_reg) begin
                    halted_next = 1'b1;
                    grp_next    = '0;
                    fill_next   = 4'd0;
                    elast_next  = 1'b1;
                    estat_next  = lpid_pkg::STATUS_DIST_ERR;
                    state_next  = ST_EMIT;
                end else begin
                    // clip at image end; room is below 259 when it wins
                    rem_next   = (room_w < {8'd0, len_w}) ? room_w[8:0] : len_w;
                    rptr_next  = back_w[AW] ? AW'(back_w + DEPTH_EXT) : back_w[AW-1:0];
                    grp_next   = '0;
                    fill_next  = 4'd0;
                    estat_next = lpid_pkg::STATUS_OK;
                    state_next = ST_RD;
                end
            end
            ST_RD: begin
                win_re     = 1'b1;
                rptr_next  = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
                state_next = ST_WR;
            end
            ST_WR: begin
                win_we    = 1'b1;
                win_wdata = win_rdata;
                wptr_next = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
                done_next = done_reg + 17'd1;
                rem_next  = rem_reg - 9'd1;
                grp_next[{fill_reg[2:0], 3'b000} +: 8] = win_rdata;
                fill_next = fill_reg + 4'd1;
                if ((fill_reg + 4'd1 == GRP_N) || (rem_reg == 9'd1)) begin
                    elast_next = (rem_reg == 9'd1);
                    state_next = ST_EMIT;
                end else begin
                    state_next = ST_RD;
                end
            end
            ST_EMIT: begin
                if (!mv_reg || m_ready) begin
                    mv_next    = 1'b1;
                    ms_next    = estat_reg;
                    mg_next    = grp_reg;
                    mc_next    = fill_reg;
                    ml_next    = elast_reg;
                    grp_next   = '0;
                    fill_next  = 4'd0;
                    state_next = elast_reg ? ST_IDLE : ST_RD;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            done_reg   <= '0;
            total_reg  <= lpid_pkg::TOTAL_RESET;
            flag_reg   <= '0;
            pos_reg    <= lpid_pkg::FLAGS_PER_CTRL;
            phase_reg  <= 1'b0;
            plen_reg   <= '0;
            halted_reg <= 1'b0;
            wptr_reg   <= '0;
            fill_reg   <= '0;
            grp_reg    <= '0;
            mv_reg     <= 1'b0;
        end else begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            total_reg  <= total_next;
            flag_reg   <= flag_next;
            pos_reg    <= pos_next;
            phase_reg  <= phase_next;
            plen_reg   <= plen_next;
            halted_reg <= halted_next;
            wptr_reg   <= wptr_next;
            fill_reg   <= fill_next;
            grp_reg    <= grp_next;
            mv_reg     <= mv_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        dist_reg  <= dist_next;
        rptr_reg  <= rptr_next;
        rem_reg   <= rem_next;
        elast_reg <= elast_next;
        estat_reg <= estat_next;
        ms_reg    <= ms_next;
        mg_reg    <= mg_next;
        mc_reg    <= mc_next;
        ml_reg    <= ml_next;
    end

endmodule

### rtl/lpid_checker.sv
// ----------------------------------------------------------------------------
// lpid_checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lpid_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_status,
    input logic [63:0] m_pixel_group,
    input logic [3:0]  m_pixel_count,
    input logic        m_last_of_token
);

    // a stalled beat holds
    `ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_pixel_group))

    // error beat carries no pixels and closes the token
    `ASSERT_IMPL(a_err_shape, aclk, aresetn, m_valid && (m_status == lpid_pkg::STATUS_DIST_ERR), (m_pixel_count == 4'd0) && m_last_of_token && (m_pixel_group == 64'd0))

    // pixel beat carries one to eight pixels
    `ASSERT_IMPL(a_cnt_range, aclk, aresetn, m_valid && (m_status == lpid_pkg::STATUS_OK), (m_pixel_count != 4'd0) && (m_pixel_count <= 4'd8))

    // after an error is taken the block goes quiet and keeps draining bytes
    `ASSERT_NEXT(a_halt, aclk, aresetn, m_valid && m_ready && (m_status == lpid_pkg::STATUS_DIST_ERR), !m_valid && s_ready)

    // a single-pixel beat has its upper bytes clear
    `ASSERT_IMPL(a_one_px, aclk, aresetn, m_valid && (m_pixel_count == 4'd1), m_pixel_group[63:8] == 56'd0)

endmodule

bind lzss_pixel_index_decoder lpid_checker u_lpid_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_pixel_group   (m_pixel_group),
    .m_pixel_count   (m_pixel_count),
    .m_last_of_token (m_last_of_token)
);

### bench/lzss_pixel_index_decoder_tb.sv
// ----------------------------------------------------------------------------
// lzss_pixel_index_decoder_tb
// Self-checking bench for the LZSS pixel index decoder. A directed table walks
// the corner cases, then random well-formed token streams run in phases, each
// under its own image total. A behavioral decoder predicts every output beat.
// The run closes with a distance error, which halts the block for good.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lzss_pixel_index_decoder_tb;

    // A distance error can only be provoked while fewer than 256 pixels are
    // decoded, and only one reset is available. So the whole run keeps the
    // pixel count below this cap and ends with the error.
    localparam logic [16:0] PIXEL_CAP      = 17'd240;
    localparam int unsigned RANDOM_ITEMS   = 150;
    localparam int unsigned SETTLE_CYCLES  = 20;    // covers a control/length byte still in flight
    localparam int unsigned WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up

    typedef struct packed {
        logic        status;
        logic [63:0] group;
        logic [3:0]  count;
        logic        last;
    } pix_result_t;

    typedef enum bit {ROW_BYTE, ROW_CFG} row_kind_t;

    // One directed step: a stream byte or a total_pixels write. Rows marked
    // typed carry their expected beats by hand; the rest use the predictor.
    typedef struct packed {
        row_kind_t   kind;
        logic [16:0] value;
        bit          typed;
        logic [1:0]  want_n;
        pix_result_t want;
    } stim_row_t;

    localparam pix_result_t NO_BEAT = '0;

    // ------------------------------------------------------------------------
    // DUT signals; the inputs are at known values from time zero
    // ------------------------------------------------------------------------
    logic        aclk            = 1'b0;
    logic        aresetn         = 1'b0;
    logic        s_valid         = 1'b0;
    logic        s_ready;
    logic [7:0]  s_stream_byte   = 8'h00;
    logic        m_valid;
    logic        m_ready         = 1'b0;
    logic        m_status;
    logic [63:0] m_pixel_group;
    logic [3:0]  m_pixel_count;
    logic        m_last_of_token;
    logic        cfg_valid       = 1'b0;
    logic        cfg_ready;
    logic [16:0] cfg_data        = 17'd0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    lzss_pixel_index_decoder i_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_stream_byte   (s_stream_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_pixel_group   (m_pixel_group),
        .m_pixel_count   (m_pixel_count),
        .m_last_of_token (m_last_of_token),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Decoder model state (mirrors the block, updated on each accepted beat)
    // ------------------------------------------------------------------------
    logic [7:0]  window_px [65536];   // history, indexed by pixel number mod 64K
    logic [16:0] img_total   = lpid_pkg::TOTAL_RESET;
    logic [16:0] px_done     = '0;
    logic [7:0]  flags       = '0;
    logic [3:0]  flag_pos    = lpid_pkg::FLAGS_PER_CTRL;
    logic        expect_dist = 1'b0;
    logic [7:0]  held_len    = '0;
    bit          stopped     = 1'b0;

    pix_result_t expected_groups [$];
    int unsigned fail_count  = 0;
    bit          no_gaps     = 1'b0;  // when set, neither side idles
    int unsigned quiet_cycles = 0;
    int unsigned ready_hold   = 0;
    int unsigned ready_draw;

    // Append one predicted beat at the tail of the queue.
    function automatic void add_beat(input pix_result_t r);
        expected_groups.insert(expected_groups.size(), r);
    endfunction

    // Decode one stream byte; queues the beats it causes and returns how many.
    function automatic int unsigned decode_byte(input logic [7:0] b);
        logic [16:0] offset;
        logic [16:0] len;
        logic [16:0] room;
        logic [16:0] src;
        logic [16:0] rd;
        logic [7:0]  px;
        logic [63:0] acc;
        int unsigned fill;
        int unsigned n;
        pix_result_t r;
        acc  = '0;
        fill = 0;
        n    = 0;
        if (stopped || px_done >= img_total)
            return 0;
        if (!expect_dist) begin
            if (flag_pos >= lpid_pkg::FLAGS_PER_CTRL) begin
                flags    = b;
                flag_pos = '0;
                return 0;
            end
            if (!flags[flag_pos[2:0]]) begin
                window_px[px_done[15:0]] = b;
                px_done  = px_done + 17'd1;
                flag_pos = flag_pos + 4'd1;
                r = '{lpid_pkg::STATUS_OK, {56'd0, b}, 4'd1, 1'b1};
                add_beat(r);
                return 1;
            end
            held_len    = b;
            expect_dist = 1'b1;
            return 0;
        end
        // distance byte closes the match token
        expect_dist = 1'b0;
        flag_pos    = flag_pos + 4'd1;
        offset = 17'(b) + 17'(lpid_pkg::DIST_BIAS);
        len    = 17'(held_len) + 17'(lpid_pkg::MATCH_BIAS);
        room   = img_total - px_done;
        if (offset > px_done) begin
            stopped = 1'b1;
            r = '{lpid_pkg::STATUS_DIST_ERR, 64'd0, 4'd0, 1'b1};
            add_beat(r);
            return 1;
        end
        if (len > room)
            len = room;
        src = px_done - offset;
        for (int j = 0; j < int'(len); j++) begin
            rd = src + 17'(j);
            px = window_px[rd[15:0]];
            window_px[px_done[15:0]] = px;
            px_done = px_done + 17'd1;
            acc  = acc | (64'(px) << (8 * fill));
            fill = fill + 1;
            if (fill == 8 || j + 1 == int'(len)) begin
                r = '{lpid_pkg::STATUS_OK, acc, 4'(fill), (j + 1 == int'(len))};
                add_beat(r);
                n    = n + 1;
                acc  = '0;
                fill = 0;
            end
        end
        return n;
    endfunction

    // Next byte of a well-formed stream, chosen from where the parser stands.
    function automatic logic [7:0] next_token_byte();
        logic [7:0]  ctrl;
        int unsigned reach;
        if (flag_pos >= lpid_pkg::FLAGS_PER_CTRL) begin
            if ($urandom_range(0, 5) == 0) begin
                ctrl = 8'($urandom_range(0, 255));
            end else begin
                for (int k = 0; k < 8; k++)
                    ctrl[k] = ($urandom_range(0, 9) < 4);   // literals dominate
            end
            if (px_done == 0)
                ctrl[0] = 1'b0;   // nothing to copy from yet
            return ctrl;
        end
        if (!flags[flag_pos[2:0]])
            return 8'($urandom_range(0, 255));
        if (!expect_dist) begin
            case ($urandom_range(0, 9))
                7, 8:    return 8'($urandom_range(5, 60));
                9:       return 8'($urandom_range(0, 255));
                default: return 8'($urandom_range(0, 4));
            endcase
        end
        reach = (px_done > 17'd256) ? 256 : int'(px_done);
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, (reach > 8) ? 7 : reach - 1));
        return 8'($urandom_range(0, reach - 1));
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random back-pressure and the beat checker
    // ------------------------------------------------------------------------
    // After each taken beat, draw how long m_ready drops before the next one.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_hold <= 0;
        end else if (m_ready && m_valid) begin
            ready_draw = no_gaps ? 0 : $urandom_range(0, 4);
            m_ready    <= (ready_draw == 0);
            ready_hold <= ready_draw;
        end else if (!m_ready) begin
            if (ready_hold <= 1)
                m_ready <= 1'b1;
            ready_hold <= (ready_hold > 0) ? ready_hold - 1 : 0;
        end
    end

    // Every output beat is matched against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_groups.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual %0h/%0h/%0h/%0h",
                         $time, m_status, m_pixel_group, m_pixel_count, m_last_of_token);
                fail_count++;
            end else begin
                check_field("status", 64'(expected_groups[0].status), 64'(m_status));
                check_field("pixel_group", expected_groups[0].group, m_pixel_group);
                check_field("pixel_count", 64'(expected_groups[0].count),
                            64'(m_pixel_count));
                check_field("last_of_token", 64'(expected_groups[0].last),
                            64'(m_last_of_token));
                void'(expected_groups.pop_front());
            end
        end
    end

    // Watchdog: too long without any beat on any channel means a hang.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d beats outstanding",
                     $time, expected_groups.size());
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stream side
    // ------------------------------------------------------------------------
    // Offer one byte after a random gap, hold it until taken, then predict.
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input int unsigned want_n = 0,
                             input pix_result_t want = '0);
        int unsigned gap;
        int unsigned made;
        gap = no_gaps ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_stream_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        made = decode_byte(b);
        if (typed) begin
            // hand-written expectation replaces the predicted one
            repeat (made) void'(expected_groups.pop_back());
            repeat (want_n) add_beat(want);
        end
    endtask

    // Stop the stream, let every beat drain, then allow a byte still in
    // flight (one that makes no beat) to finish.
    task automatic settle();
        s_valid <= 1'b0;
        while (expected_groups.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_total(input logic [16:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        img_total = v;
    endtask

    // ------------------------------------------------------------------------
    // Directed table. Pixel history after row 11: FF 00 80 01 55 AA 7F 3C.
    // ------------------------------------------------------------------------
    stim_row_t stim_table [0:25] = '{
        // reset total (64K) in force: control byte, all literals
        '{ROW_BYTE, 17'h000, 1'b1, 2'd0, NO_BEAT},
        '{ROW_BYTE, 17'h0FF, 1'b1, 2'd1, '{lpid_pkg::STATUS_OK, 64'hFF, 4'd1, 1'b1}},
        // smallest nonzero total: image is already complete, byte is dropped
        '{ROW_CFG,  17'd1,   1'b0, 2'd0, NO_BEAT},
        '{ROW_BYTE, 17'h05A, 1'b1, 2'd0, NO_BEAT},
        // largest total: decoding resumes inside the same control byte
        '{ROW_CFG,  17'd65536, 1'b0, 2'd0, NO_BEAT},
        '{ROW_BYTE, 17'h000, 1'b1, 2'd1, '{lpid_pkg::STATUS_OK, 64'h00, 4'd1, 1'b1}},
        '{ROW_BYTE, 17'h080, 1'b0, 2'd0, NO_BEAT},
        '{ROW_BYTE, 17'h001, 1'b0, 2'd0, NO_BEAT},
        '{ROW_BYTE, 17'h055, 1'b0, 2'd0, NO_BEAT},
        '{ROW_BYTE, 17'h0AA, 1'b0, 2'd0, NO_BEAT},
        '{ROW_BYTE, 17'h07F, 1'b0, 2'd0, NO_BEAT},
        '{ROW_BYTE, 17'h03C, 1'b1, 2'd1, '{lpid_pkg::STATUS_OK, 64'h3C, 4'd1, 1'b1}},
        // control byte, all matches
        '{ROW_BYTE, 17'h0FF, 1'b1, 2'd0, NO_BEAT},
        // shortest match at distance one: overlapping repeat of the last pixel
        '{ROW_BYTE, 17'h000, 1'b1, 2'd0, NO_BEAT},
        '{ROW_BYTE, 17'h000, 1'b1, 2'd1, '{lpid_pkg::STATUS_OK, 64'h3C3C3C, 4'd3, 1'b1}},
        // full group copied from the first pixel
        '{ROW_BYTE, 17'h005, 1'b0, 2'd0, NO_BEAT},
        '{ROW_BYTE, 17'h00A, 1'b0, 2'd0, NO_BEAT},
        // longest match, cut short at the total (8 + 8 + 5 pixels)
        '{ROW_CFG,  17'd40,  1'b0, 2'd0, NO_BEAT},
        '{ROW_BYTE, 17'h0FF, 1'b0, 2'd0, NO_BEAT},
        '{ROW_BYTE, 17'h000, 1'b0, 2'd0, NO_BEAT},
        '{ROW_BYTE, 17'h011, 1'b1, 2'd0, NO_BEAT},
        // zero total: everything ignored
        '{ROW_CFG,  17'd0,   1'b0, 2'd0, NO_BEAT},
        '{ROW_BYTE, 17'h022, 1'b1, 2'd0, NO_BEAT},
        // back open; match reaching exactly to the first pixel
        '{ROW_CFG,  17'd65536, 1'b0, 2'd0, NO_BEAT},
        '{ROW_BYTE, 17'h002, 1'b0, 2'd0, NO_BEAT},
        '{ROW_BYTE, 17'h027, 1'b0, 2'd0, NO_BEAT}
    };

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int unsigned counted;
        logic [16:0] next_total;
        counted = 0;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_table[i]) begin
            if (stim_table[i].kind == ROW_CFG) begin
                settle();
                write_total(stim_table[i].value);
            end else begin
                send_byte(stim_table[i].value[7:0], stim_table[i].typed,
                          stim_table[i].want_n, stim_table[i].want);
            end
        end

        // Random phases: each opens a little more of the image, fills it with
        // well-formed tokens, then throws a few bytes at the completed image.
        while (px_done < PIXEL_CAP && counted < RANDOM_ITEMS) begin
            settle();
            next_total = px_done + 17'($urandom_range(1, 40));
            if (next_total > PIXEL_CAP)
                next_total = PIXEL_CAP;
            no_gaps = ($urandom_range(0, 3) == 0);
            write_total(next_total);
            while (px_done < img_total) begin
                send_byte(next_token_byte());
                counted++;
            end
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
        end

        // Closing phase: open the image fully, steer to a match token and give
        // it the farthest distance, which lies before the first pixel.
        settle();
        no_gaps = 1'b0;
        write_total(lpid_pkg::TOTAL_RESET);
        while (!stopped) begin
            if (flag_pos >= lpid_pkg::FLAGS_PER_CTRL)
                send_byte(8'hFF);
            else if (!flags[flag_pos[2:0]])
                send_byte(8'($urandom_range(0, 255)));
            else if (!expect_dist)
                send_byte(8'($urandom_range(0, 255)));
            else
                send_byte(8'hFF, 1'b1, 1, '{lpid_pkg::STATUS_DIST_ERR, 64'd0, 4'd0, 1'b1});
        end
        // halted: further bytes are swallowed without a beat
        repeat (3) send_byte(8'($urandom_range(0, 255)));
        settle();

        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
